// File: hdl/btndb_pkg.sv
// ---------------------------------------------------------------------------
// btndb_pkg
// shared constants for the button debounce and autorepeat block
// ---------------------------------------------------------------------------
package btndb_pkg;

  // time counter width
  localparam int TimeBitsDefault = 32;

  // configuration port
  localparam int CfgIndexBits = 8;
  localparam int CfgDataBits  = 16;

  localparam logic [CfgIndexBits-1:0] RegAgreeThreshold  = 8'd0;
  localparam logic [CfgIndexBits-1:0] RegSampleDelay     = 8'd1;
  localparam logic [CfgIndexBits-1:0] RegHeldMs          = 8'd2;
  localparam logic [CfgIndexBits-1:0] RegRepeatInitialMs = 8'd3;
  localparam logic [CfgIndexBits-1:0] RegRepeatInterval  = 8'd4;

  // register reset values
  localparam logic [7:0]  AgreeThresholdReset  = 8'd3;
  localparam logic [7:0]  SampleDelayReset     = 8'd5;
  localparam logic [15:0] HeldMsReset          = 16'd1000;
  localparam logic [15:0] RepeatInitialMsReset = 16'd500;
  localparam logic [15:0] RepeatIntervalReset  = 16'd100;

  // stream widths
  localparam int InDataBits  = 8;
  localparam int DurBits     = 32;
  localparam int OutDataBits = 40;

  localparam logic [8:0] DisagreeMax = 9'd511;

endpackage

// File: hdl/button_debounce_autorepeat.sv
// ---------------------------------------------------------------------------
// button_debounce_autorepeat
// debounced push button with press/release events, held flag and autorepeat
// ---------------------------------------------------------------------------
// Each input transfer is one millisecond tick carrying the raw button level;
// each tick gives exactly one result transfer with the debounced state, press
// and release pulses, the on-time at release, the held flag and autorepeat
// pulses. The block takes one tick per clock cycle while the result stream
// is not stalled: a tick is registered at the input, evaluated against the
// debounce and timing state in one pass, and its result lands in the output
// register; the input keeps flowing while a result waits as long as the output
// register frees up in the same cycle. Configuration writes take effect for
// ticks evaluated afterwards and should be made while no tick is in flight.
// ---------------------------------------------------------------------------
module button_debounce_autorepeat #(
  parameter int TIME_BITS = btndb_pkg::TimeBitsDefault
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // input tick stream
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [btndb_pkg::InDataBits-1:0]     s_axis_tdata,   // [0] raw_pressed
  // result stream
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // [0] button_on, [1] press_pulse, [2] release_pulse, [34:3] on_duration,
  // [35] held_flag, [36] repeat_pulse
  output logic [btndb_pkg::OutDataBits-1:0]    m_axis_tdata,
  // configuration writes
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [btndb_pkg::CfgIndexBits-1:0]   cfg_index,
  input  logic [btndb_pkg::CfgDataBits-1:0]    cfg_data
);

  localparam int TW = TIME_BITS;

  // configuration registers
  logic [7:0]  agree_threshold;
  logic [7:0]  sample_delay;
  logic [15:0] held_ms;
  logic [15:0] repeat_initial_ms;
  logic [15:0] repeat_interval_ms;

  // input register
  logic in_valid;
  logic in_raw;

  // debounce and timing state
  logic          debounced;
  logic [8:0]    disagree_count;
  logic [7:0]    sample_timer;
  logic [TW-1:0] since_change;
  logic [TW-1:0] repeat_target;
  logic          repeat_started;

  logic          debounced_next;
  logic [8:0]    disagree_count_next;
  logic [7:0]    sample_timer_next;
  logic [TW-1:0] since_change_next;
  logic [TW-1:0] repeat_target_next;
  logic          repeat_started_next;

  logic [TW-1:0] since_inc;
  logic [8:0]    disagree_inc;
  logic [TW-1:0] target_mid;
  logic [TW-1:0] rep_step;
  logic [TW:0]   target_sum;
  logic [TW+btndb_pkg::DurBits-1:0] since_ext;

  logic press;
  logic release_ev;
  logic held;
  logic rep;
  logic [btndb_pkg::DurBits-1:0] duration;

  logic advance;

  assign cfg_ready     = 1'b1;
  assign advance       = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      agree_threshold    <= btndb_pkg::AgreeThresholdReset;
      sample_delay       <= btndb_pkg::SampleDelayReset;
      held_ms            <= btndb_pkg::HeldMsReset;
      repeat_initial_ms  <= btndb_pkg::RepeatInitialMsReset;
      repeat_interval_ms <= btndb_pkg::RepeatIntervalReset;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        btndb_pkg::RegAgreeThreshold:  agree_threshold    <= cfg_data[7:0];
        btndb_pkg::RegSampleDelay:     sample_delay       <= cfg_data[7:0];
        btndb_pkg::RegHeldMs:          held_ms            <= cfg_data;
        btndb_pkg::RegRepeatInitialMs: repeat_initial_ms  <= cfg_data;
        btndb_pkg::RegRepeatInterval:  repeat_interval_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_raw <= s_axis_tdata[0];
    end
  end

  always_comb begin
    since_inc    = (since_change == {TW{1'b1}}) ? since_change : since_change + 1'b1;
    disagree_inc = (disagree_count < btndb_pkg::DisagreeMax) ?
                   disagree_count + 1'b1 : disagree_count;
    since_ext    = {{btndb_pkg::DurBits{1'b0}}, since_inc};

    debounced_next      = debounced;
    disagree_count_next = disagree_count;
    sample_timer_next   = sample_timer;
    since_change_next   = since_inc;
    target_mid          = repeat_target;
    repeat_started_next = repeat_started;
    press               = 1'b0;
    release_ev          = 1'b0;
    duration            = '0;

    if (sample_timer >= sample_delay) begin
      sample_timer_next = '0;
      if (in_raw != debounced) begin
        disagree_count_next = disagree_inc;
        if (disagree_inc > 9'(agree_threshold)) begin
          debounced_next      = !debounced;
          disagree_count_next = '0;
          since_change_next   = '0;
          if (!debounced) begin
            press               = 1'b1;
            repeat_started_next = 1'b0;
            target_mid          = '0;
          end else begin
            release_ev = 1'b1;
            // clamp the on-time to the result field width
            duration   = (|since_ext[TW+btndb_pkg::DurBits-1:btndb_pkg::DurBits]) ?
                         {btndb_pkg::DurBits{1'b1}} : since_ext[btndb_pkg::DurBits-1:0];
          end
        end
      end else begin
        disagree_count_next = '0;
      end
    end else begin
      sample_timer_next = sample_timer + 1'b1;
    end

    // next repeat target, saturating on carry out
    rep_step   = repeat_started_next ? TW'(repeat_interval_ms) : TW'(repeat_initial_ms);
    target_sum = {1'b0, target_mid} + {1'b0, rep_step};

    held               = 1'b0;
    rep                = 1'b0;
    repeat_target_next = target_mid;
    if (debounced_next) begin
      held = since_change_next > TW'(held_ms);
      if (since_change_next > target_mid) begin
        rep                 = 1'b1;
        repeat_started_next = 1'b1;
        repeat_target_next  = target_sum[TW] ? {TW{1'b1}} : target_sum[TW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      debounced      <= 1'b0;
      disagree_count <= '0;
      sample_timer   <= '0;
      since_change   <= '0;
      repeat_target  <= '0;
      repeat_started <= 1'b0;
    end else if (advance) begin
      debounced      <= debounced_next;
      disagree_count <= disagree_count_next;
      sample_timer   <= sample_timer_next;
      since_change   <= since_change_next;
      repeat_target  <= repeat_target_next;
      repeat_started <= repeat_started_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_axis_tdata <= {3'b000, rep, held, duration, release_ev, press, debounced_next};
    end
  end

endmodule
